>>> hdl/mrpt_pkg.sv
`default_nettype none
package mrpt_pkg;
  localparam int unsigned WIDTH = 64;
  localparam int unsigned BASE_TABLE_LEN = 12;
  localparam int unsigned NUM_BASES_DEFAULT = 9;

  typedef logic [WIDTH-1:0] word_t;

  typedef struct packed {
    logic   load;
    logic   pow_start;
    logic   sqr_start;
    logic [3:0] base_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic   done;
    logic   special;
    logic   special_val;
    logic   base_ge_n;
    logic   x_is_one;
    logic   x_is_nm1;
    logic   r_left;
  } dp_stat_t;

  function automatic logic [5:0] base_value(input logic [3:0] idx);
    logic [5:0] v;
    begin
      case (idx)
        4'd0: v = 6'd2;
        4'd1: v = 6'd3;
        4'd2: v = 6'd5;
        4'd3: v = 6'd7;
        4'd4: v = 6'd11;
        4'd5: v = 6'd13;
        4'd6: v = 6'd17;
        4'd7: v = 6'd19;
        4'd8: v = 6'd23;
        4'd9: v = 6'd29;
        4'd10: v = 6'd31;
        4'd11: v = 6'd37;
        default: v = 6'd37;
      endcase
      return v;
    end
  endfunction
endpackage
`default_nettype wire

>>> hdl/mrpt_mulmod.sv
`default_nettype none
// Serial modular multiply: acc = x*y mod m, one bit of y per cycle.
module mrpt_mulmod (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire mrpt_pkg::word_t x,
  input  wire mrpt_pkg::word_t y,
  input  wire mrpt_pkg::word_t m,
  output logic               done,
  output mrpt_pkg::word_t    prod
);
  import mrpt_pkg::*;

  word_t xr, yr, acc;
  logic [6:0] cnt;
  logic busy;
  word_t dbl, nxt;
  logic [WIDTH:0] s1, s2;

  always_comb begin
    s1 = {1'b0, acc} + {1'b0, acc};
    dbl = (s1 >= {1'b0, m}) ? WIDTH'(s1 - {1'b0, m}) : s1[WIDTH-1:0];
    s2 = {1'b0, dbl} + {1'b0, xr};
    if (yr[WIDTH-1])
      nxt = (s2 >= {1'b0, m}) ? WIDTH'(s2 - {1'b0, m}) : s2[WIDTH-1:0];
    else
      nxt = dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
        acc <= '0;
        xr <= x;
        yr <= y;
      end else if (busy) begin
        acc <= nxt;
        yr <= {yr[WIDTH-2:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;
endmodule
`default_nettype wire

>>> hdl/mrpt_datapath.sv
`default_nettype none
module mrpt_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mrpt_pkg::word_t number,
  input  wire mrpt_pkg::dp_cmd_t cmd,
  output mrpt_pkg::dp_stat_t stat
);
  import mrpt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_POW_MUL, S_POW_SQR, S_SQR} op_t;
  op_t op;

  word_t n, d, e, b, x, nm1;
  logic [6:0] r, rleft;
  logic mm_start, mm_done;
  word_t mm_x, mm_y, mm_p;
  logic done;
  logic [5:0] a;
  logic [6:0] tz;

  assign a = base_value(cmd.base_idx);

  always_comb begin
    tz = 7'd0;
    for (int i = WIDTH-1; i >= 1; i--) begin
      if (number[i]) tz = 7'(i);
    end
  end

  mrpt_mulmod u_mm (
    .clk(clk), .rst(rst), .start(mm_start), .x(mm_x), .y(mm_y), .m(n),
    .done(mm_done), .prod(mm_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= S_IDLE;
      mm_start <= 1'b0;
      done <= 1'b0;
    end else begin
      mm_start <= 1'b0;
      done <= 1'b0;
      if (cmd.load) begin
        n <= number;
        nm1 <= number - WIDTH'(1);
        d <= (number - WIDTH'(1)) >> ((tz == 7'd0) ? 7'd1 : tz);
        r <= (tz == 7'd0) ? 7'd1 : tz;
      end
      unique case (op)
        S_IDLE: begin
          if (cmd.pow_start) begin
            x <= WIDTH'(1);
            b <= WIDTH'(a);
            e <= d;
            rleft <= r - 7'd1;
            op <= S_POW_MUL;
            mm_x <= WIDTH'(1);
            mm_y <= WIDTH'(a);
            mm_start <= 1'b1;
          end else if (cmd.sqr_start) begin
            mm_x <= x;
            mm_y <= x;
            mm_start <= 1'b1;
            rleft <= rleft - 7'd1;
            op <= S_SQR;
          end
        end
        S_POW_MUL: if (mm_done) begin
          if (e[0]) x <= mm_p;
          mm_x <= b;
          mm_y <= b;
          mm_start <= 1'b1;
          op <= S_POW_SQR;
        end
        S_POW_SQR: if (mm_done) begin
          b <= mm_p;
          e <= e >> 1;
          if ((e >> 1) == '0) begin
            op <= S_IDLE;
            done <= 1'b1;
          end else begin
            mm_x <= x;
            mm_y <= mm_p;
            mm_start <= 1'b1;
            op <= S_POW_MUL;
          end
        end
        S_SQR: if (mm_done) begin
          x <= mm_p;
          op <= S_IDLE;
          done <= 1'b1;
        end
        default: op <= S_IDLE;
      endcase
    end
  end

  // n < 4 or even: settled without modular work
  always_comb begin
    stat.special = (number[WIDTH-1:2] == '0) || !number[0];
    stat.special_val = (number == WIDTH'(2)) || (number == WIDTH'(3));
    stat.done = done;
    stat.base_ge_n = (n <= WIDTH'(a));
    stat.x_is_one = (x == WIDTH'(1));
    stat.x_is_nm1 = (x == nm1);
    stat.r_left = (rleft != 7'd0);
  end
endmodule
`default_nettype wire

>>> hdl/mrpt_ctrl.sv
`default_nettype none
module mrpt_ctrl #(
  parameter int unsigned NUM_BASES = mrpt_pkg::NUM_BASES_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic      is_prime,
  input  wire mrpt_pkg::dp_stat_t stat,
  output mrpt_pkg::dp_cmd_t cmd
);
  import mrpt_pkg::*;

  localparam int unsigned LIMIT = (NUM_BASES > BASE_TABLE_LEN) ? BASE_TABLE_LEN : NUM_BASES;

  typedef enum logic [2:0] {ST_IDLE, ST_BASE, ST_POW, ST_CHECK, ST_SQR, ST_OUT} state_t;
  state_t state;
  logic [3:0] idx;
  logic load, pow_start, sqr_start;
  logic pow_check;

  // n is captured at the accepting edge, while the word is still on the port
  assign load = (state == ST_IDLE) && in_valid && !stat.special;
  assign in_stall = (state != ST_IDLE);
  assign cmd.load = load;
  assign cmd.pow_start = pow_start;
  assign cmd.sqr_start = sqr_start;
  assign cmd.base_idx = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      pow_start <= 1'b0;
      sqr_start <= 1'b0;
      pow_check <= 1'b0;
      idx <= '0;
    end else begin
      pow_start <= 1'b0;
      sqr_start <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_valid) begin
          if (stat.special) begin
            is_prime <= stat.special_val;
            out_valid <= 1'b1;
            state <= ST_OUT;
          end else begin
            idx <= '0;
            state <= ST_BASE;
          end
        end
        ST_BASE: begin
          if (32'(idx) >= LIMIT || stat.base_ge_n) begin
            is_prime <= 1'b1;
            out_valid <= 1'b1;
            state <= ST_OUT;
          end else begin
            pow_start <= 1'b1;
            pow_check <= 1'b1;
            state <= ST_POW;
          end
        end
        ST_POW, ST_SQR: if (stat.done) state <= ST_CHECK;
        ST_CHECK: begin
          // x == 1 passes only straight after the power, not after a squaring
          if ((pow_check && stat.x_is_one) || stat.x_is_nm1) begin
            idx <= idx + 4'd1;
            state <= ST_BASE;
          end else if (stat.r_left) begin
            sqr_start <= 1'b1;
            pow_check <= 1'b0;
            state <= ST_SQR;
          end else begin
            is_prime <= 1'b0;
            out_valid <= 1'b1;
            state <= ST_OUT;
          end
        end
        ST_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(is_prime));
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall);
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(pow_start && sqr_start));
endmodule
`default_nettype wire

>>> hdl/miller_rabin_prime_test.sv
`default_nettype none
// Channel  Direction  Handshake                 Word
// in       input      in_valid / in_stall       number[63:0]
// out      output     out_valid / out_stall     is_prime
// One word in, one verdict out. Below 4 or even: verdict valid the cycle after acceptance.
// Otherwise each base runs square-and-multiply over d, then up to r-1 squarings;
// each multiply is a 64-bit bit-serial modular multiply.
// A base takes at most 126 multiplies; by default up to nine bases are tried.
// Reset (rst, synchronous) returns the controller to idle.
// in_stall stays high from acceptance until the verdict is taken.
module miller_rabin_prime_test #(
  parameter int unsigned NUM_BASES = mrpt_pkg::NUM_BASES_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire mrpt_pkg::word_t number,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               is_prime
);
  import mrpt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mrpt_ctrl #(.NUM_BASES(NUM_BASES)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .is_prime(is_prime),
    .stat(stat), .cmd(cmd)
  );

  mrpt_datapath u_dp (
    .clk(clk), .rst(rst), .number(number), .cmd(cmd), .stat(stat)
  );
endmodule
`default_nettype wire
